### sv/keyboard_report_key_event_diff_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the keyboard report differ
// Concurrent assertion wrappers that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef KEYBOARD_REPORT_KEY_EVENT_DIFF_TOP_DEFINES_SVH
`define KEYBOARD_REPORT_KEY_EVENT_DIFF_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// ante implies cons in the same cycle
`define KRED_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// ante implies cons in the following cycle
`define KRED_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define KRED_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define KRED_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

### sv/kred_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kred_pkg
// Shared types, constants and the usage-to-button lookup.
// ----------------------------------------------------------------------------
package kred_pkg;

    localparam int SLOT_CAP   = 6;
    localparam int KEY_W      = 8;
    localparam int BTN_W      = 4;
    localparam int IN_W       = SLOT_CAP * KEY_W;
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // usage codes
    localparam logic [KEY_W-1:0] USE_ENTER    = 8'h28;
    localparam logic [KEY_W-1:0] USE_ESCAPE   = 8'h29;
    localparam logic [KEY_W-1:0] USE_LEFT     = 8'h50;
    localparam logic [KEY_W-1:0] USE_RIGHT    = 8'h4F;
    localparam logic [KEY_W-1:0] USE_UP       = 8'h52;
    localparam logic [KEY_W-1:0] USE_DOWN     = 8'h51;
    localparam logic [KEY_W-1:0] USE_KP_ENTER = 8'h58;
    localparam logic [KEY_W-1:0] USE_F1       = 8'h3A;
    localparam logic [KEY_W-1:0] USE_F2       = 8'h3B;
    localparam logic [KEY_W-1:0] USE_F3       = 8'h3C;
    localparam logic [KEY_W-1:0] USE_F4       = 8'h3D;

    // button codes
    localparam logic [BTN_W-1:0] BTN_ACCEPT = 4'd0;
    localparam logic [BTN_W-1:0] BTN_BACK   = 4'd1;
    localparam logic [BTN_W-1:0] BTN_LEFT   = 4'd2;
    localparam logic [BTN_W-1:0] BTN_RIGHT  = 4'd3;
    localparam logic [BTN_W-1:0] BTN_UP     = 4'd4;
    localparam logic [BTN_W-1:0] BTN_DOWN   = 4'd5;
    localparam logic [BTN_W-1:0] BTN_STICK  = 4'd6;
    localparam logic [BTN_W-1:0] BTN_HOME   = 4'd7;
    localparam logic [BTN_W-1:0] BTN_MENU   = 4'd8;
    localparam logic [BTN_W-1:0] BTN_SELECT = 4'd9;
    localparam logic [BTN_W-1:0] BTN_START  = 4'd10;

    typedef struct packed {
        logic [BTN_W-1:0] button;
        logic             is_press;
        logic             last;
    } t_event;

    typedef struct packed {
        logic             empty;
        logic             full;
        logic [CNT_W-1:0] count;
    } t_fifo_stat;

    typedef struct packed {
        logic             mapped;
        logic [BTN_W-1:0] button;
    } t_lookup;

    function automatic t_lookup f_button(input logic [KEY_W-1:0] usage);
        t_lookup res;
        res.mapped = 1'b1;
        unique case (usage)
            USE_ENTER:    res.button = BTN_ACCEPT;
            USE_ESCAPE:   res.button = BTN_BACK;
            USE_LEFT:     res.button = BTN_LEFT;
            USE_RIGHT:    res.button = BTN_RIGHT;
            USE_UP:       res.button = BTN_UP;
            USE_DOWN:     res.button = BTN_DOWN;
            USE_KP_ENTER: res.button = BTN_STICK;
            USE_F1:       res.button = BTN_HOME;
            USE_F2:       res.button = BTN_MENU;
            USE_F3:       res.button = BTN_SELECT;
            USE_F4:       res.button = BTN_START;
            default: begin
                res.mapped = 1'b0;
                res.button = BTN_ACCEPT;
            end
        endcase
        return res;
    endfunction

endpackage

### sv/keyboard_report_key_event_diff_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyboard_report_key_event_diff_top
// Boot-keyboard report differ: turns key reports into button press and
// release events.
// ----------------------------------------------------------------------------
// Usage:
//  - s_axis carries one report per word: six 8-bit key usage codes, 0 = empty.
//    Only the first KEY_SLOTS slots take part; the rest are ignored.
//  - m_axis carries one event per word: button code in tdata, tuser high for
//    a press and low for a release, tlast on the final event of a report.
//  - Events of one report: releases of vanished keys in slot order, then
//    presses of new keys in slot order; unmapped keys give no event.
//  - Path: the first event of a report passes the front's event mask, the queue
//    and the output register before it is on m_axis. Events then leave one per
//    cycle while m_axis_tready is high.
//  - Throughput: the compare front holds a report until it has pushed its N
//    events (N at most 2*KEY_SLOTS = 12); it pushes one event a cycle into a
//    four-word queue while the queue is not full. The next report is taken the
//    cycle after the front pushed the last event of the current one.
//  - Stall: a stalled m_axis fills the queue, then the front waits, then
//    s_axis_tready stays low. Nothing is dropped.
//  - Reset (i_rst_n low, synchronous): stored report cleared to all empty,
//    queue and output register emptied.
`include "keyboard_report_key_event_diff_top_defines.svh"

module keyboard_report_key_event_diff_top #(
    parameter int KEY_SLOTS = 6
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // key_slot_0 [7:0], key_slot_1 [15:8], ... key_slot_5 [47:40]
    input  logic [kred_pkg::IN_W-1:0]  s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // button_code [3:0], zero fill [7:4]
    output logic [7:0]                 m_axis_tdata,
    // is_press [0]
    output logic                       m_axis_tuser,
    output logic                       m_axis_tlast
);

    logic                  w_front_ready;
    logic                  w_push_valid;
    kred_pkg::t_event      w_push_evt;
    logic                  w_pop;
    kred_pkg::t_event      w_head;
    kred_pkg::t_fifo_stat  w_fifo_stat;
    kred_pkg::t_event      w_out_evt;

    // compare front: one report at a time, events out lowest first
    kred_front #(
        .KEY_SLOTS (KEY_SLOTS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .i_data       (s_axis_tdata),
        .o_ready      (w_front_ready),
        .o_push_valid (w_push_valid),
        .o_push_evt   (w_push_evt),
        .i_push_ready (!w_fifo_stat.full)
    );

    // decoupling queue
    kred_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push_valid),
        .i_push_evt (w_push_evt),
        .i_pop      (w_pop),
        .o_head     (w_head),
        .o_stat     (w_fifo_stat)
    );

    // output register stage
    kred_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_fifo_stat.empty),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_valid (m_axis_tvalid),
        .o_evt   (w_out_evt),
        .i_ready (m_axis_tready)
    );

    assign s_axis_tready = w_front_ready;
    assign m_axis_tdata  = {{(8 - kred_pkg::BTN_W){1'b0}}, w_out_evt.button};
    assign m_axis_tuser  = w_out_evt.is_press;
    assign m_axis_tlast  = w_out_evt.last;

    // an event that is not the last of its report always has a successor
    // waiting in the queue or still in the front
    `KRED_ASSERT_NOW(a_successor_pending, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tlast, !w_fifo_stat.empty || w_push_valid,
        "non-last event without pending successor")

    // queue occupancy never exceeds its depth
    `KRED_ASSERT_NOW(a_fifo_bound, i_clk, i_rst_n,
        1'b1, w_fifo_stat.count <= kred_pkg::CNT_W'(kred_pkg::FIFO_DEPTH),
        "event queue overflow")

    // a report is taken only when no event of the previous one is left in the front
    `KRED_ASSERT_NOW(a_accept_front_idle, i_clk, i_rst_n,
        s_axis_tvalid && s_axis_tready, !w_push_valid,
        "report accepted while front still busy")

endmodule

### sv/kred_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kred_front
// Takes a report, compares it with the stored one and hands out the
// resulting events one per cycle while the queue has room, releases first, in slot order.
// ----------------------------------------------------------------------------
module kred_front #(
    parameter int KEY_SLOTS = 6
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [kred_pkg::IN_W-1:0]   i_data,
    output logic                        o_ready,
    output logic                        o_push_valid,
    output kred_pkg::t_event            o_push_evt,
    input  logic                        i_push_ready
);

    localparam int EV_N = 2 * KEY_SLOTS;

    logic [kred_pkg::KEY_W-1:0] r_prev [KEY_SLOTS];
    logic [kred_pkg::KEY_W-1:0] w_now  [KEY_SLOTS];
    logic [kred_pkg::BTN_W-1:0] r_code [EV_N];
    logic [kred_pkg::BTN_W-1:0] w_code [EV_N];
    logic [EV_N-1:0]            r_mask;
    logic [EV_N-1:0]            n_mask;
    logic [EV_N-1:0]            w_onehot;
    logic                       w_accept;
    logic                       w_push;

    // candidate events: bits [KEY_SLOTS-1:0] releases, upper bits presses
    always_comb begin
        logic             hit;
        kred_pkg::t_lookup lk;
        for (int i = 0; i < KEY_SLOTS; i++) begin
            w_now[i] = i_data[i*kred_pkg::KEY_W +: kred_pkg::KEY_W];
        end
        for (int i = 0; i < KEY_SLOTS; i++) begin
            hit = 1'b0;
            for (int j = 0; j < KEY_SLOTS; j++) begin
                if (w_now[j] == r_prev[i]) hit = 1'b1;
            end
            lk        = kred_pkg::f_button(r_prev[i]);
            n_mask[i] = (r_prev[i] != '0) && !hit && lk.mapped;
            w_code[i] = lk.button;
        end
        for (int i = 0; i < KEY_SLOTS; i++) begin
            hit = 1'b0;
            for (int j = 0; j < KEY_SLOTS; j++) begin
                if (r_prev[j] == w_now[i]) hit = 1'b1;
            end
            lk                    = kred_pkg::f_button(w_now[i]);
            n_mask[KEY_SLOTS + i] = (w_now[i] != '0) && !hit && lk.mapped;
            w_code[KEY_SLOTS + i] = lk.button;
        end
    end

    // lowest pending event goes out next
    always_comb begin
        w_onehot = r_mask & (~r_mask + {{(EV_N-1){1'b0}}, 1'b1});
        o_push_evt.button = '0;
        for (int i = 0; i < EV_N; i++) begin
            if (w_onehot[i]) o_push_evt.button = o_push_evt.button | r_code[i];
        end
        o_push_evt.is_press = |w_onehot[EV_N-1:KEY_SLOTS];
        o_push_evt.last     = ((r_mask & ~w_onehot) == '0);
    end

    assign o_ready      = (r_mask == '0);
    assign o_push_valid = |r_mask;
    assign w_accept     = i_valid && o_ready;
    assign w_push       = o_push_valid && i_push_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
            for (int i = 0; i < KEY_SLOTS; i++) r_prev[i] <= '0;
        end else if (w_accept) begin
            r_mask <= n_mask;
            for (int i = 0; i < KEY_SLOTS; i++) r_prev[i] <= w_now[i];
        end else if (w_push) begin
            r_mask <= r_mask & ~w_onehot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            for (int i = 0; i < EV_N; i++) r_code[i] <= w_code[i];
        end
    end

endmodule

### sv/kred_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kred_fifo
// Short event queue between the compare front and the output stage.
// ----------------------------------------------------------------------------
module kred_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  kred_pkg::t_event      i_push_evt,
    input  logic                  i_pop,
    output kred_pkg::t_event      o_head,
    output kred_pkg::t_fifo_stat  o_stat
);

    kred_pkg::t_event              r_mem [kred_pkg::FIFO_DEPTH];
    logic [kred_pkg::PTR_W-1:0]    r_wptr;
    logic [kred_pkg::PTR_W-1:0]    r_rptr;
    logic [kred_pkg::CNT_W-1:0]    r_count;
    logic                          w_push;
    logic                          w_pop;

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == kred_pkg::CNT_W'(kred_pkg::FIFO_DEPTH));
    assign o_stat.count = r_count;
    assign o_head       = r_mem[r_rptr];

    assign w_push = i_push && !o_stat.full;
    assign w_pop  = i_pop && !o_stat.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) r_wptr <= r_wptr + 1'b1;
            if (w_pop)  r_rptr <= r_rptr + 1'b1;
            if (w_push && !w_pop)      r_count <= r_count + 1'b1;
            else if (w_pop && !w_push) r_count <= r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wptr] <= i_push_evt;
    end

endmodule

### sv/kred_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kred_back
// Output register: pulls events from the queue and holds them on the
// master stream until taken.
// ----------------------------------------------------------------------------
module kred_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_empty,
    input  kred_pkg::t_event      i_head,
    output logic                  o_pop,
    output logic                  o_valid,
    output kred_pkg::t_event      o_evt,
    input  logic                  i_ready
);

    logic             r_valid;
    kred_pkg::t_event r_evt;

    assign o_pop   = !i_empty && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_evt   = r_evt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_evt <= i_head;
    end

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the boot-keyboard report differ. Reports go in
// on s_axis from a queue of pending words; a scoreboard tracks the stored
// report, predicts the release and press events of each accepted report,
// and checks every event word leaving m_axis in order.
// ----------------------------------------------------------------------------
module tb;

    import kred_pkg::*;

    localparam int REPORT_SLOTS = 6;     // slots the block compares and stores
    localparam int QUIET_LIMIT  = 3000;  // cycles without any handshake
    localparam int DRAIN_CYCLES = 32;    // settle time after the last event
    localparam int RANDOM_WORDS = 230;
    localparam int CALM_FROM    = 150;   // no idling on either side for
    localparam int CALM_TO      = 200;   //   reports in this range
    localparam int HOLD_AT      = 80;    // receiver back-pressure trigger
    localparam int HOLD_CYCLES  = 300;

    // usage codes that carry a button, in button order
    localparam logic [KEY_W-1:0] BUTTON_USAGE [11] = '{
        USE_ENTER, USE_ESCAPE, USE_LEFT, USE_RIGHT, USE_UP, USE_DOWN,
        USE_KP_ENTER, USE_F1, USE_F2, USE_F3, USE_F4
    };

    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                s_axis_tvalid  = 1'b0;
    logic                s_axis_tready;
    // key_slot_0 [7:0], key_slot_1 [15:8], ... key_slot_5 [47:40]
    logic [IN_W-1:0]     s_axis_tdata   = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready  = 1'b0;
    // button_code [3:0], zero fill [7:4]
    logic [7:0]          m_axis_tdata;
    // is_press [0]
    logic                m_axis_tuser;
    logic                m_axis_tlast;

    keyboard_report_key_event_diff_top #(
        .KEY_SLOTS(REPORT_SLOTS)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Scoreboard state
    // ------------------------------------------------------------------
    logic [IN_W-1:0]  report_q[$];             // reports waiting to be driven
    t_event           key_event_q[$];          // events still owed by the block
    logic [KEY_W-1:0] held_keys [SLOT_CAP] = '{default: '0};  // last report
    int               reports_taken = 0;
    int               fail_count    = 0;
    int               quiet_cycles  = 0;
    int               hold_left     = 0;
    bit               hold_done     = 1'b0;

    function automatic logic [IN_W-1:0] pack_report(
        input logic [KEY_W-1:0] k0, input logic [KEY_W-1:0] k1,
        input logic [KEY_W-1:0] k2, input logic [KEY_W-1:0] k3,
        input logic [KEY_W-1:0] k4, input logic [KEY_W-1:0] k5);
        return {k5, k4, k3, k2, k1, k0};
    endfunction

    // Mostly keys with a button, some empty slots, some arbitrary bytes.
    function automatic logic [KEY_W-1:0] pick_key();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return BUTTON_USAGE[$urandom_range(0, 10)];
        else if (roll < 85)
            return '0;
        else
            return KEY_W'($urandom_range(0, 255));
    endfunction

    // Returns 1 and the button when the usage code has a mapping.
    function automatic bit usage_to_button(input logic [KEY_W-1:0] usage,
                                           output logic [BTN_W-1:0] button);
        button = BTN_ACCEPT;
        case (usage)
            USE_ENTER:    button = BTN_ACCEPT;
            USE_ESCAPE:   button = BTN_BACK;
            USE_LEFT:     button = BTN_LEFT;
            USE_RIGHT:    button = BTN_RIGHT;
            USE_UP:       button = BTN_UP;
            USE_DOWN:     button = BTN_DOWN;
            USE_KP_ENTER: button = BTN_STICK;
            USE_F1:       button = BTN_HOME;
            USE_F2:       button = BTN_MENU;
            USE_F3:       button = BTN_SELECT;
            USE_F4:       button = BTN_START;
            default:      return 1'b0;
        endcase
        return 1'b1;
    endfunction

    function automatic bit slots_hold(input logic [KEY_W-1:0] slots [SLOT_CAP],
                                      input logic [KEY_W-1:0] usage);
        for (int i = 0; i < REPORT_SLOTS; i++)
            if (slots[i] == usage)
                return 1'b1;
        return 1'b0;
    endfunction

    // Releases of vanished keys first, then presses of new keys, each in
    // slot order; tlast goes on the final event of the report.
    function automatic void predict_key_events(input logic [IN_W-1:0] report);
        logic [KEY_W-1:0] now_keys [SLOT_CAP];
        logic [KEY_W-1:0] k;
        logic [BTN_W-1:0] btn;
        t_event           ev;
        t_event           found[$];
        for (int i = 0; i < SLOT_CAP; i++)
            now_keys[i] = (i < REPORT_SLOTS) ? report[i*KEY_W +: KEY_W] : '0;
        for (int i = 0; i < REPORT_SLOTS; i++) begin
            k = held_keys[i];
            if (k != '0 && !slots_hold(now_keys, k) && usage_to_button(k, btn)) begin
                ev.button   = btn;
                ev.is_press = 1'b0;
                ev.last     = 1'b0;
                found.push_back(ev);
            end
        end
        for (int i = 0; i < REPORT_SLOTS; i++) begin
            k = now_keys[i];
            if (k != '0 && !slots_hold(held_keys, k) && usage_to_button(k, btn)) begin
                ev.button   = btn;
                ev.is_press = 1'b1;
                ev.last     = 1'b0;
                found.push_back(ev);
            end
        end
        if (found.size() > 0)
            found[found.size()-1].last = 1'b1;
        foreach (found[i])
            key_event_q.push_back(found[i]);
        held_keys = now_keys;
    endfunction

    // ------------------------------------------------------------------
    // Driver: one report word per handshake from report_q. tvalid stays
    // up with stable data until the word is taken.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        bit calm;
        calm = (reports_taken >= CALM_FROM) && (reports_taken < CALM_TO);
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (s_axis_tvalid && !s_axis_tready) begin
            // hold the offered word
        end else if (report_q.size() > 0 && (calm || $urandom_range(0, 99) >= 33)) begin
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= report_q.pop_front();
        end else begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predicts on input handshakes and checks output words in the
    // same process, so the expectation is always queued first. It also
    // paces m_axis_tready, including one long hold-off that backs the
    // block up into s_axis.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_event want;
        bit     ready_next;
        bit     calm;
        calm = (reports_taken >= CALM_FROM) && (reports_taken < CALM_TO);
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_key_events(s_axis_tdata);
                reports_taken <= reports_taken + 1;
            end

            if (m_axis_tvalid && m_axis_tready) begin
                if (key_event_q.size() == 0) begin
                    $error("unexpected event word: button_code %0d is_press %0d last %0d",
                           m_axis_tdata[3:0], m_axis_tuser, m_axis_tlast);
                    fail_count++;
                end else begin
                    want = key_event_q.pop_front();
                    if (m_axis_tdata[3:0] !== want.button) begin
                        $error("button_code mismatch: expected %0d, actual %0d",
                               want.button, m_axis_tdata[3:0]);
                        fail_count++;
                    end
                    if (m_axis_tdata[7:4] !== 4'd0) begin
                        $error("tdata zero fill mismatch: expected 0, actual %0d",
                               m_axis_tdata[7:4]);
                        fail_count++;
                    end
                    if (m_axis_tuser !== want.is_press) begin
                        $error("is_press mismatch: expected %0d, actual %0d",
                               want.is_press, m_axis_tuser);
                        fail_count++;
                    end
                    if (m_axis_tlast !== want.last) begin
                        $error("last_event mismatch: expected %0d, actual %0d",
                               want.last, m_axis_tlast);
                        fail_count++;
                    end
                end
            end

            if (hold_left > 0) begin
                hold_left  <= hold_left - 1;
                ready_next = 1'b0;
            end else if (!hold_done && reports_taken >= HOLD_AT) begin
                hold_left  <= HOLD_CYCLES;
                hold_done  <= 1'b1;
                ready_next = 1'b0;
            end else if (calm) begin
                ready_next = 1'b1;
            end else begin
                ready_next = ($urandom_range(0, 99) >= 33);
            end
            m_axis_tready <= ready_next;
        end
    end

    // cycles since the last handshake on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        logic [IN_W-1:0] cur;
        logic [63:0]     raw;
        int              mode;
        int              slot;
        bit              timed_out;
        timed_out = 1'b0;

        // Directed: empty report after reset, single key press/hold/release,
        // full reports, the twelve-event maximum through repeated codes,
        // unmapped keys, a key moving between slots, all-ones and
        // alternating bit patterns.
        report_q.push_back('0);
        report_q.push_back(pack_report(USE_ENTER, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        report_q.push_back(pack_report(USE_ENTER, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        report_q.push_back('0);
        report_q.push_back(pack_report(USE_ENTER, USE_ESCAPE, USE_LEFT,
                                       USE_RIGHT, USE_UP, USE_DOWN));
        report_q.push_back(pack_report(USE_KP_ENTER, USE_F1, USE_F2,
                                       USE_F3, USE_F4, USE_ENTER));
        report_q.push_back('0);
        report_q.push_back(pack_report(USE_ENTER, USE_ENTER, USE_ENTER,
                                       USE_ENTER, USE_ENTER, USE_ENTER));
        // six releases, six presses
        report_q.push_back(pack_report(USE_ESCAPE, USE_ESCAPE, USE_ESCAPE,
                                       USE_ESCAPE, USE_ESCAPE, USE_ESCAPE));
        report_q.push_back(pack_report(8'h04, USE_LEFT, 8'hFF, 8'h00, USE_F4, 8'h80));
        // same key in another slot: no event for it
        report_q.push_back(pack_report(8'h00, 8'h00, 8'hFF, 8'h04, 8'h80, USE_LEFT));
        report_q.push_back({IN_W{1'b1}});
        report_q.push_back({(IN_W/2){2'b10}});
        report_q.push_back({(IN_W/2){2'b01}});
        report_q.push_back(pack_report(USE_F1, 8'h00, USE_F1, USE_F1, 8'h7F, USE_UP));
        report_q.push_back(pack_report(USE_UP, 8'h01, USE_F1, 8'hE0, 8'h00, USE_F1));
        report_q.push_back(pack_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, USE_DOWN));
        report_q.push_back(pack_report(USE_DOWN, USE_DOWN, USE_F3, USE_F2,
                                       USE_KP_ENTER, USE_RIGHT));
        report_q.push_back('0);

        // Random: mostly small edits of the held report, like real typing,
        // with full rewrites, noise and empties mixed in.
        cur = '0;
        repeat (RANDOM_WORDS) begin
            mode = $urandom_range(0, 99);
            if (mode < 60) begin
                repeat ($urandom_range(1, 3)) begin
                    slot = $urandom_range(0, SLOT_CAP - 1);
                    cur[slot*KEY_W +: KEY_W] = pick_key();
                end
            end else if (mode < 85) begin
                for (int i = 0; i < SLOT_CAP; i++)
                    cur[i*KEY_W +: KEY_W] = pick_key();
            end else if (mode < 95) begin
                raw = {$urandom(), $urandom()};
                cur = raw[IN_W-1:0];
            end else begin
                cur = '0;
            end
            report_q.push_back(cur);
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Sample away from the active edge so the queues are settled.
        forever begin
            @(negedge i_clk);
            if (report_q.size() == 0 && !s_axis_tvalid && key_event_q.size() == 0)
                break;
            if (quiet_cycles >= QUIET_LIMIT) begin
                timed_out = 1'b1;
                break;
            end
        end
        if (!timed_out)
            repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (!timed_out && fail_count == 0 && key_event_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### files.f
+incdir+sv
sv/kred_pkg.sv
sv/kred_front.sv
sv/kred_fifo.sv
sv/kred_back.sv
sv/keyboard_report_key_event_diff_top.sv
dv/tb.sv
